// ----- sv/complex_pole_resonator_filter_macros.svh -----
// assertion macros for the complex pole resonator filter
// included by the modules that carry concurrent checks; no other dependencies
`ifndef COMPLEX_POLE_RESONATOR_FILTER_MACROS_SVH
`define COMPLEX_POLE_RESONATOR_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define CPR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/cpr_pkg.sv -----
// shared types and constants of the complex pole resonator filter
// no dependencies
`timescale 1ns / 1ps

package cpr_pkg;

  // field and datapath widths
  localparam int unsigned SAMPLE_W  = 24;  // Q1.23 samples
  localparam int unsigned COEF_W    = 24;  // Q3.20 coefficients
  localparam int unsigned STATE_W   = 32;  // Q8.23 pole state
  localparam int unsigned FIR_PROD_W = SAMPLE_W + COEF_W;       // 48
  localparam int unsigned FIR_W     = FIR_PROD_W + 2;           // sum of three taps
  localparam int unsigned POLE_PROD_W = STATE_W + COEF_W;       // 56
  localparam int unsigned ACC_W     = POLE_PROD_W + 2;          // 58
  localparam int unsigned RND_SHIFT = 20;                       // 2^-43 -> 2^-23
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_TAP0 = 3'd0,
    REG_ZERO_TAP1 = 3'd1,
    REG_ZERO_TAP2 = 3'd2,
    REG_POLE_REAL = 3'd3,
    REG_POLE_IMAG = 3'd4
  } cpr_reg_e;

  // coefficient set handed from the register file to the datapath
  typedef struct packed {
    logic signed [COEF_W-1:0] zero_tap0;
    logic signed [COEF_W-1:0] zero_tap1;
    logic signed [COEF_W-1:0] zero_tap2;
    logic signed [COEF_W-1:0] pole_real;
    logic signed [COEF_W-1:0] pole_imag;
  } cpr_coef_t;

endpackage

// ----- sv/cpr_cfg_regs.sv -----
// coefficient register file of the complex pole resonator filter
// depends on cpr_pkg
`timescale 1ns / 1ps

module cpr_cfg_regs import cpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i,
  output cpr_coef_t            coef_o
);

  cpr_coef_t coef_q, coef_d;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cpr_reg_e'(cfg_idx_i))
        REG_ZERO_TAP0: coef_d.zero_tap0 = cfg_wdata_i;
        REG_ZERO_TAP1: coef_d.zero_tap1 = cfg_wdata_i;
        REG_ZERO_TAP2: coef_d.zero_tap2 = cfg_wdata_i;
        REG_POLE_REAL: coef_d.pole_real = cfg_wdata_i;
        REG_POLE_IMAG: coef_d.pole_imag = cfg_wdata_i;
        default:       coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ----- sv/cpr_zero_fir.sv -----
// two-zero front end: three-tap fir over the current and two previous samples
// depends on cpr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "complex_pole_resonator_filter_macros.svh"

module cpr_zero_fir import cpr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cpr_coef_t                  coef_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  output logic                       s_valid_o,
  input  logic                       s_ready_i,
  output logic signed [FIR_W-1:0]    s_o
);

  logic signed [SAMPLE_W-1:0]   prev_in1_q, prev_in2_q;
  logic signed [FIR_W-1:0]      s_q, s_d;
  logic                         s_valid_q, s_valid_d;
  logic signed [FIR_PROD_W-1:0] prod0, prod1, prod2;
  logic                         accept;

  // stage is free when empty or draining this cycle
  assign in_ready_o = !s_valid_q || s_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // tap products and their exact sum at scale 2^-43
  assign prod0 = coef_i.zero_tap0 * in_sample_i;
  assign prod1 = coef_i.zero_tap1 * prev_in1_q;
  assign prod2 = coef_i.zero_tap2 * prev_in2_q;

  always_comb begin
    s_d       = FIR_W'(prod0) + FIR_W'(prod1) + FIR_W'(prod2);
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (s_ready_i) begin
      s_valid_d = 1'b0;
    end
  end

  // sample history and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in1_q <= '0;
      prev_in2_q <= '0;
      s_valid_q  <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
      if (accept) begin
        prev_in1_q <= in_sample_i;
        prev_in2_q <= prev_in1_q;
      end
    end
  end

  // fir result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= s_d;
    end
  end

  assign s_valid_o = s_valid_q;
  assign s_o       = s_q;

  // history shifts by one word on each accepted sample
  `CPR_ASSERT_NEXT(a_hist_shift, clk_i, rst_ni, accept,
    prev_in1_q == $past(in_sample_i) && prev_in2_q == $past(prev_in1_q),
    "sample history did not shift on accept")

endmodule

// ----- sv/cpr_pole_stage.sv -----
// complex one-pole recursion, rounding, saturation and the output register
// depends on cpr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "complex_pole_resonator_filter_macros.svh"

module cpr_pole_stage import cpr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cpr_coef_t                  coef_i,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic signed [FIR_W-1:0]    s_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  // round half up to scale 2^-23 and clamp to the state range
  function automatic logic signed [STATE_W-1:0] round_sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shf;
    logic [ACC_W-STATE_W:0]  top;
    rnd = v + (ACC_W'(1) <<< (RND_SHIFT - 1));
    shf = rnd >>> RND_SHIFT;
    top = shf[ACC_W-1:STATE_W-1];
    if (&top || ~|top) begin
      return shf[STATE_W-1:0];
    end else if (shf[ACC_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // clamp a state value to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(logic signed [STATE_W-1:0] v);
    logic [STATE_W-SAMPLE_W:0] top;
    top = v[STATE_W-1:SAMPLE_W-1];
    if (&top || ~|top) begin
      return v[SAMPLE_W-1:0];
    end else if (v[STATE_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  logic signed [STATE_W-1:0]     state_re_q, state_re_d;
  logic signed [STATE_W-1:0]     state_im_q, state_im_d;
  logic signed [POLE_PROD_W-1:0] prod_rr, prod_ii, prod_ri, prod_ir;
  logic signed [ACC_W-1:0]       acc_re, acc_im;
  logic signed [SAMPLE_W-1:0]    out_sample_q;
  logic                          out_valid_q, out_valid_d;
  logic                          load;

  // output register frees up when empty or taken this cycle
  assign s_ready_o = !out_valid_q || out_ready_i;
  assign load      = s_valid_i && s_ready_o;

  // complex feedback products a * p_prev
  assign prod_rr = coef_i.pole_real * state_re_q;
  assign prod_ii = coef_i.pole_imag * state_im_q;
  assign prod_ri = coef_i.pole_real * state_im_q;
  assign prod_ir = coef_i.pole_imag * state_re_q;

  // p = s - a * p_prev at scale 2^-43, then back to Q8.23
  always_comb begin
    acc_re      = ACC_W'(s_i) - (ACC_W'(prod_rr) - ACC_W'(prod_ii));
    acc_im      = -(ACC_W'(prod_ri) + ACC_W'(prod_ir));
    state_re_d  = round_sat(acc_re);
    state_im_d  = round_sat(acc_im);
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // pole state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_re_q  <= '0;
      state_im_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        state_re_q <= state_re_d;
        state_im_q <= state_im_d;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sample_q <= sat_sample(state_im_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

  // recursion only advances with a word entering the output register
  `CPR_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !load,
    $stable(state_re_q) && $stable(state_im_q),
    "pole state changed without a word")

  // an in-range imaginary state is passed to the output unchanged
  `CPR_ASSERT_IMPLIES(a_out_match, clk_i, rst_ni,
    out_valid_q && (&state_im_q[STATE_W-1:SAMPLE_W-1] || ~|state_im_q[STATE_W-1:SAMPLE_W-1]),
    out_sample_q == state_im_q[SAMPLE_W-1:0],
    "output word does not match pole state")

endmodule

// ----- sv/complex_pole_resonator_filter.sv -----
// top level of the complex pole resonator filter
// depends on cpr_pkg, cpr_cfg_regs, cpr_zero_fir and cpr_pole_stage
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / in_sample_i) takes one signed
//   Q1.23 sample per word; output channel (out_valid_o / out_ready_i /
//   out_sample_o) returns one Q1.23 sample per input word, in order.
//   Coefficients are loaded through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the filter is idle: index 0..2 the zero taps, 3 and 4 the real and
//   imaginary pole parts, all signed Q3.20; other indexes are ignored.
//   A word is held first in the fir register and then passes through the pole
//   recursion into the output register. Throughput is one word per cycle
//   while out_ready_i is high; the complex multiply-accumulate feedback on
//   the pole state is combinational.
//   Reset clears coefficients, sample history, pole state and both valid
//   flags. When the receiver stalls, the output word holds, the fir
//   register can still take one more word, and then in_ready_o drops until
//   the output is taken.

module complex_pole_resonator_filter import cpr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [COEF_W-1:0]          cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  cpr_coef_t               coef;
  logic                    s_valid;
  logic                    s_ready;
  logic signed [FIR_W-1:0] s_data;

  // coefficient registers
  cpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // two-zero front end
  cpr_zero_fir u_fir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_sample_i (in_sample_i),
    .s_valid_o   (s_valid),
    .s_ready_i   (s_ready),
    .s_o         (s_data)
  );

  // complex pole recursion and output register
  cpr_pole_stage u_pole (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (coef),
    .s_valid_i    (s_valid),
    .s_ready_o    (s_ready),
    .s_i          (s_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o)
  );

endmodule
